@@ design/seven_segment_scan_driver_macros.svh @@
// ----------------------------------------------------------------------------
// Seven-segment scan driver assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define SSD_ASSERT_SAME(lbl, clk, rst_n, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("seven segment scan driver: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSD_ASSERT_NEXT(lbl, clk, rst_n, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("seven segment scan driver: next-cycle check failed");

`else

`define SSD_ASSERT_SAME(lbl, clk, rst_n, ant, cons)
`define SSD_ASSERT_NEXT(lbl, clk, rst_n, ant, cons)

`endif

`endif

@@ design/ssd_pkg.sv @@
// ----------------------------------------------------------------------------
// Seven-segment scan driver package
// Sizes, codes, request and result types and the glyph table.
// ----------------------------------------------------------------------------
package ssd_pkg;

  // Characters per bank; a power of two.
  localparam int BUFFER_BYTES = 32;
  localparam int MAX_DIGITS   = 8;

  // Counters and pointers must hold BUFFER_BYTES itself.
  localparam int PTR_W  = $clog2(BUFFER_BYTES) + 1;
  // One bank bit above the character position.
  localparam int ADDR_W = $clog2(2 * BUFFER_BYTES);
  localparam int DIG_W  = 3;
  localparam int NUM_W  = 4;

  localparam logic [7:0] CHAR_DOT = 8'h2E;
  localparam logic [7:0] SEG_DOT  = 8'h80;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_REFRESH = 1'b1
  } opcode_t;

  typedef enum logic {
    RES_WRITE = 1'b0,
    RES_DRIVE = 1'b1
  } res_kind_t;

  typedef enum logic [1:0] {
    CFG_ENABLE        = 2'd0,
    CFG_NUM_DIGITS    = 2'd1,
    CFG_COMMON_HIGH   = 2'd2,
    CFG_SEGMENTS_HIGH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic       accepted;
    logic [7:0] segment_lines;
    logic [7:0] common_lines;
  } out_item_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

  // Active-high segment pattern, bit 0 = segment a.
  function automatic logic [7:0] glyph_of(input logic [7:0] c);
    logic [7:0] g;
    unique case (c)
      8'h30:        g = 8'h3F;  // 0
      8'h31:        g = 8'h06;  // 1
      8'h32:        g = 8'h5B;  // 2
      8'h33:        g = 8'h4F;  // 3
      8'h34:        g = 8'h66;  // 4
      8'h35, 8'h53: g = 8'h6D;  // 5 S
      8'h36, 8'h42: g = 8'h7C;  // 6 B
      8'h37:        g = 8'h07;  // 7
      8'h38:        g = 8'h7F;  // 8
      8'h39, 8'h51: g = 8'h67;  // 9 Q
      8'h41:        g = 8'h77;  // A
      8'h43:        g = 8'h39;  // C
      8'h44:        g = 8'h5E;  // D
      8'h45:        g = 8'h79;  // E
      8'h46:        g = 8'h71;  // F
      8'h47:        g = 8'h3D;  // G
      8'h48:        g = 8'h76;  // H
      8'h49:        g = 8'h30;  // I
      8'h4A:        g = 8'h1E;  // J
      8'h4C:        g = 8'h38;  // L
      8'h4E:        g = 8'h54;  // N
      8'h4F:        g = 8'h5C;  // O
      8'h50:        g = 8'h73;  // P
      8'h52:        g = 8'h50;  // R
      8'h54:        g = 8'h78;  // T
      8'h55:        g = 8'h1C;  // U
      8'h56:        g = 8'h3E;  // V
      8'h59:        g = 8'h6E;  // Y
      default:      g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

@@ design/seven_segment_scan_driver.sv @@
// ----------------------------------------------------------------------------
// Seven-segment scan driver
// Double-buffered text store with string checking and multiplexed digit scan.
// ----------------------------------------------------------------------------
// Each request is accepted, the character store (a synchronous memory with
// registered read data) is read or written, and then the result is formed
// and placed in the output register, once that register is empty or being
// read. A new request is taken once the result stage has passed the last one
// on, even while that result still waits in the output register, so requests
// never overlap in the result stage. A write request without the last
// character mark yields no result; a closing write yields one status result
// and a refresh tick yields one drive result. When enable is low requests are
// still taken but are discarded without a result. The store needs no clearing
// after reset: only positions below the shown length are ever displayed, and
// these have always been written by the string that was accepted.
// ----------------------------------------------------------------------------
`include "seven_segment_scan_driver_macros.svh"

module seven_segment_scan_driver (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ssd_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ssd_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [3:0]          cfg_data
);

  localparam int PW = ssd_pkg::PTR_W;
  localparam logic [PW-1:0] FULL = PW'(ssd_pkg::BUFFER_BYTES);
  localparam logic [PW-1:0] LAST_LOOK = PW'(ssd_pkg::BUFFER_BYTES - 1);

  // Second-stage payload: what a request carries into its result cycle.
  typedef struct packed {
    logic                          emit;
    logic                          kind;
    logic                          ok;
    logic [7:0]                    com;
    logic                          v1;
    logic                          v2;
    logic [PW-1:0]                 p2;
    logic                          wrap;
  } s1_t;

  // Configuration registers.
  logic                           enable_r;
  logic [ssd_pkg::NUM_W-1:0]      num_digits_r;
  logic                           com_high_r;
  logic                           seg_high_r;

  // Display and load state.
  logic                           bank_r, bank_nxt;
  logic [PW-1:0]                  shown_len_r, shown_len_nxt;
  logic [PW-1:0]                  load_len_r, load_len_nxt;
  logic [PW-1:0]                  dots_r, dots_nxt;
  logic [PW-1:0]                  glyphs_r, glyphs_nxt;
  logic                           prev_dot_r, prev_dot_nxt;
  logic                           load_err_r, load_err_nxt;
  logic [PW-1:0]                  rp_r, rp_nxt;
  logic [ssd_pkg::DIG_W-1:0]      digit_r, digit_nxt;

  // Pipeline and output.
  logic                           s1_valid_r, s1_valid_nxt;
  s1_t                            s1_r, s1_nxt;
  logic                           out_valid_r, out_valid_nxt;
  ssd_pkg::out_item_t             out_data_r, out_data_nxt;

  // Character store: two banks, one write port, two read ports.
  logic [7:0]                     mem_r [2*ssd_pkg::BUFFER_BYTES];
  logic [7:0]                     rd1_r;
  logic [7:0]                     rd2_r;

  logic                           acc;
  logic                           work;
  logic                           is_wr;
  logic                           is_rf;
  logic                           s1_go;
  logic [7:0]                     c_up;
  logic                           is_dot;
  logic [ssd_pkg::NUM_W-1:0]      nd;
  logic                           err_n;
  logic [PW-1:0]                  dots_n;
  logic [PW-1:0]                  glyphs_n;
  logic [PW-1:0]                  len_n;
  logic                           ok;
  logic [PW-1:0]                  p2;
  logic                           wrap;
  logic [ssd_pkg::NUM_W-1:0]      d_inc;
  logic [7:0]                     com;
  logic [7:0]                     seg;
  logic                           dot_hit;
  logic [ssd_pkg::ADDR_W-1:0]     wr_addr;
  logic [ssd_pkg::ADDR_W-1:0]     rd1_addr;
  logic [ssd_pkg::ADDR_W-1:0]     rd2_addr;

  // Views of the output register used by the checks at the end.
  logic                           out_stalled;
  logic                           out_drive;
  logic                           out_status;
  logic [7:0]                     com_levels;
  logic [15:0]                    status_lines;

  // A request is taken whenever the result stage is empty; the output
  // register decouples the consumer from that decision.
  assign in_ready  = !s1_valid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign acc   = in_valid && in_ready;
  assign work  = acc && enable_r;
  assign is_wr = work && (in_data.opcode == ssd_pkg::OP_WRITE);
  assign is_rf = work && (in_data.opcode == ssd_pkg::OP_REFRESH);
  assign s1_go = s1_valid_r && (!out_valid_r || out_ready);

  // The digit count is clamped to the range the scan supports.
  always_comb begin
    if (num_digits_r == '0) begin
      nd = ssd_pkg::NUM_W'(1);
    end else if (num_digits_r > ssd_pkg::NUM_W'(ssd_pkg::MAX_DIGITS)) begin
      nd = ssd_pkg::NUM_W'(ssd_pkg::MAX_DIGITS);
    end else begin
      nd = num_digits_r;
    end
  end

  // String loading: the counts saturate at the bank size, and an overlong
  // string is refused because its length can never fall below that size.
  always_comb begin
    c_up     = ssd_pkg::to_upper(in_data.char_code);
    is_dot   = (c_up == ssd_pkg::CHAR_DOT);
    err_n    = load_err_r || (is_dot && ((load_len_r == '0) || prev_dot_r));
    dots_n   = (is_dot && dots_r != FULL) ? dots_r + PW'(1) : dots_r;
    glyphs_n = (!is_dot && glyphs_r != FULL) ? glyphs_r + PW'(1) : glyphs_r;
    len_n    = (load_len_r != FULL) ? load_len_r + PW'(1) : load_len_r;
    ok       = !err_n && (len_n < FULL) && (dots_n <= PW'(nd)) && (glyphs_n >= PW'(nd));
  end

  // Refresh addressing: the character under the read pointer and the one
  // after it, which is merged as a decimal point when it is a dot.
  always_comb begin
    p2    = (rp_r != FULL) ? rp_r + PW'(1) : rp_r;
    d_inc = ssd_pkg::NUM_W'(digit_r) + ssd_pkg::NUM_W'(1);
    wrap  = (d_inc >= nd);
    com   = 8'(1) << digit_r;
    if (!com_high_r) begin
      com = ~com;
    end
    wr_addr  = {~bank_r, load_len_r[PW-2:0]};
    rd1_addr = {bank_r, rp_r[PW-2:0]};
    rd2_addr = {bank_r, p2[PW-2:0]};
  end

  // Result formation from the registered store data, as the result stage moves on.
  always_comb begin
    dot_hit = s1_r.v2 && (rd2_r == ssd_pkg::CHAR_DOT);
    seg     = ssd_pkg::glyph_of(s1_r.v1 ? rd1_r : 8'h00);
    if (dot_hit) begin
      seg = seg | ssd_pkg::SEG_DOT;
    end
    if (!seg_high_r) begin
      seg = ~seg;
    end
  end

  // Next-state logic for everything that is not the store itself.
  always_comb begin
    bank_nxt      = bank_r;
    shown_len_nxt = shown_len_r;
    load_len_nxt  = load_len_r;
    dots_nxt      = dots_r;
    glyphs_nxt    = glyphs_r;
    prev_dot_nxt  = prev_dot_r;
    load_err_nxt  = load_err_r;
    rp_nxt        = rp_r;
    digit_nxt     = digit_r;
    s1_valid_nxt  = s1_valid_r;
    s1_nxt        = s1_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // A closing write swaps banks when the string passes, and the load
    // state starts afresh either way.
    if (is_wr) begin
      if (in_data.last_char) begin
        load_len_nxt = '0;
        dots_nxt     = '0;
        glyphs_nxt   = '0;
        prev_dot_nxt = 1'b0;
        load_err_nxt = 1'b0;
        if (ok) begin
          bank_nxt      = ~bank_r;
          shown_len_nxt = len_n;
          rp_nxt        = '0;
          digit_nxt     = '0;
        end
      end else begin
        load_len_nxt = len_n;
        dots_nxt     = dots_n;
        glyphs_nxt   = glyphs_n;
        prev_dot_nxt = is_dot;
        load_err_nxt = err_n;
      end
    end

    // The digit advances at once; the read pointer waits for the data,
    // since a merged dot moves it one further.
    if (is_rf) begin
      digit_nxt = wrap ? '0 : digit_r + ssd_pkg::DIG_W'(1);
    end

    if (acc) begin
      s1_valid_nxt = 1'b1;
      s1_nxt.emit  = work && ((in_data.opcode == ssd_pkg::OP_REFRESH) || in_data.last_char);
      s1_nxt.kind  = (in_data.opcode == ssd_pkg::OP_REFRESH) ? ssd_pkg::RES_DRIVE
                                                             : ssd_pkg::RES_WRITE;
      s1_nxt.ok    = ok;
      s1_nxt.com   = com;
      s1_nxt.v1    = (rp_r < shown_len_r);
      s1_nxt.v2    = (p2 < LAST_LOOK) && (p2 < shown_len_r);
      s1_nxt.p2    = p2;
      s1_nxt.wrap  = wrap;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
      if (s1_r.emit) begin
        out_valid_nxt = 1'b1;
        if (s1_r.kind == ssd_pkg::RES_DRIVE) begin
          out_data_nxt.result_kind   = ssd_pkg::RES_DRIVE;
          out_data_nxt.accepted      = 1'b0;
          out_data_nxt.segment_lines = seg;
          out_data_nxt.common_lines  = s1_r.com;
          rp_nxt = s1_r.wrap ? '0 : s1_r.p2 + PW'(dot_hit);
        end else begin
          out_data_nxt.result_kind   = ssd_pkg::RES_WRITE;
          out_data_nxt.accepted      = s1_r.ok;
          out_data_nxt.segment_lines = 8'h00;
          out_data_nxt.common_lines  = 8'h00;
        end
      end
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b1;
      num_digits_r <= ssd_pkg::NUM_W'(4);
      com_high_r   <= 1'b1;
      seg_high_r   <= 1'b1;
      bank_r       <= 1'b0;
      shown_len_r  <= '0;
      load_len_r   <= '0;
      dots_r       <= '0;
      glyphs_r     <= '0;
      prev_dot_r   <= 1'b0;
      load_err_r   <= 1'b0;
      rp_r         <= '0;
      digit_r      <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (ssd_pkg::cfg_reg_t'(cfg_index))
          ssd_pkg::CFG_ENABLE:        enable_r     <= cfg_data[0];
          ssd_pkg::CFG_NUM_DIGITS:    num_digits_r <= cfg_data;
          ssd_pkg::CFG_COMMON_HIGH:   com_high_r   <= cfg_data[0];
          ssd_pkg::CFG_SEGMENTS_HIGH: seg_high_r   <= cfg_data[0];
        endcase
      end
      bank_r      <= bank_nxt;
      shown_len_r <= shown_len_nxt;
      load_len_r  <= load_len_nxt;
      dots_r      <= dots_nxt;
      glyphs_r    <= glyphs_nxt;
      prev_dot_r  <= prev_dot_nxt;
      load_err_r  <= load_err_nxt;
      rp_r        <= rp_nxt;
      digit_r     <= digit_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    s1_r       <= s1_nxt;
    out_data_r <= out_data_nxt;
  end

  // Character store. Writes go to the staging bank, reads to the shown one;
  // only one request is in flight, so the two never meet in the same cycle.
  always_ff @(posedge clk) begin
    if (is_wr && (load_len_r != FULL)) begin
      mem_r[wr_addr] <= c_up;
    end
    if (is_rf) begin
      rd1_r <= mem_r[rd1_addr];
      rd2_r <= mem_r[rd2_addr];
    end
  end

  assign out_stalled  = s1_valid_r && out_valid_r && !out_ready;
  assign out_drive    = out_valid_r && (out_data_r.result_kind == ssd_pkg::RES_DRIVE);
  assign out_status   = out_valid_r && (out_data_r.result_kind == ssd_pkg::RES_WRITE);
  assign com_levels   = out_data_r.common_lines ^ {8{!com_high_r}};
  assign status_lines = {out_data_r.segment_lines, out_data_r.common_lines};

  // A waiting result must not be overwritten by the request behind it.
  `SSD_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_stalled, s1_valid_r && out_valid_r)
  // A shown string always fits the bank with room to spare.
  `SSD_ASSERT_SAME(a_shown_fits, clk, rst_n, 1'b1, shown_len_r < FULL && rp_r <= FULL)
  // A drive result has exactly one common line at its active level.
  `SSD_ASSERT_SAME(a_one_common, clk, rst_n, out_drive, $onehot(com_levels))
  // A status result carries no drive levels.
  `SSD_ASSERT_SAME(a_status_clean, clk, rst_n, out_status, status_lines == 16'h0000)

endmodule

@@ tb/seven_segment_scan_driver_test.sv @@
// ----------------------------------------------------------------------------
// Seven-segment scan driver testbench
// Loads text strings and refresh ticks into the driver, predicts every status
// and drive result from its own model of the text banks and the digit scan,
// and compares each returned result field by field, under random idling on
// both sides, register sweeps and a long output stall.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver_test;
  timeunit 1ns;
  timeprecision 1ps;

  // The run stops once this many requests have been taken while enabled.
  localparam int ITEM_TARGET = 1700;
  // Cycles without any handshake before the run is declared hung. The longest
  // correct quiet spell is set by the deliberate output hold.
  localparam int STALL_LIMIT = 2000;
  // Length of the deliberate output hold used to fill the block.
  localparam int HOLD_CYCLES = 300;
  // A closing-free write may still be in flight when the last result arrives;
  // this settling time covers it with margin.
  localparam int SETTLE_CYCLES = 6;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  ssd_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  ssd_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [3:0]         cfg_data = '0;

  seven_segment_scan_driver u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Our own view of the driver: register copies, both text banks, the loading
  // counters and the scan position.
  // --------------------------------------------------------------------------
  bit         set_enable;
  logic [3:0] set_digits;
  bit         set_com_high;
  bit         set_seg_high;

  logic [7:0] text_store [0:2*ssd_pkg::BUFFER_BYTES-1];
  bit         shown_bank;
  int         shown_len;
  int         load_len;
  int         dots_seen;
  int         glyphs_seen;
  bit         last_was_dot;
  bit         load_bad;
  int         scan_pos;
  int         scan_digit;

  // Results that the driver still owes us, oldest first.
  ssd_pkg::out_item_t results_due [$];

  // Bookkeeping for the closing summary and the verdict.
  int         fault_count;
  int         items_counted;
  int         strings_shown;
  int         strings_refused;
  int         drives_seen;
  int         reg_writes;

  // Stimulus shaping for the sender and the receiver, and the hang counter.
  bit         steady;
  bit         hold_armed;
  int         rx_gap;
  int         stall_cycles;

  logic [7:0]         text_buf [$];
  ssd_pkg::out_item_t head_result;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= "a" && c <= "z") return c - 8'd32;
    return c;
  endfunction

  // Active-high segment pattern for one character; anything unknown is blank.
  function automatic logic [7:0] segments_for(input logic [7:0] c);
    case (c)
      "0":      return 8'h3F;
      "1":      return 8'h06;
      "2":      return 8'h5B;
      "3":      return 8'h4F;
      "4":      return 8'h66;
      "5", "S": return 8'h6D;
      "6", "B": return 8'h7C;
      "7":      return 8'h07;
      "8":      return 8'h7F;
      "9", "Q": return 8'h67;
      "A":      return 8'h77;
      "C":      return 8'h39;
      "D":      return 8'h5E;
      "E":      return 8'h79;
      "F":      return 8'h71;
      "G":      return 8'h3D;
      "H":      return 8'h76;
      "I":      return 8'h30;
      "J":      return 8'h1E;
      "L":      return 8'h38;
      "N":      return 8'h54;
      "O":      return 8'h5C;
      "P":      return 8'h73;
      "R":      return 8'h50;
      "T":      return 8'h78;
      "U":      return 8'h1C;
      "V":      return 8'h3E;
      "Y":      return 8'h6E;
      default:  return 8'h00;
    endcase
  endfunction

  // The digit count register is honoured only within 1..MAX_DIGITS.
  function automatic int digits_in_use();
    if (set_digits == 0) return 1;
    if (set_digits > ssd_pkg::MAX_DIGITS) return ssd_pkg::MAX_DIGITS;
    return set_digits;
  endfunction

  // Positions beyond the shown string read as a blank NUL.
  function automatic logic [7:0] shown_at(input int pos);
    if (pos >= shown_len || pos >= ssd_pkg::BUFFER_BYTES) return 8'h00;
    return text_store[(shown_bank ? ssd_pkg::BUFFER_BYTES : 0) + pos];
  endfunction

  task automatic reset_panel_model();
    set_enable   = 1'b1;
    set_digits   = 4'd4;
    set_com_high = 1'b1;
    set_seg_high = 1'b1;
    for (int i = 0; i < 2 * ssd_pkg::BUFFER_BYTES; i++) text_store[i] = 8'h00;
    shown_bank   = 1'b0;
    shown_len    = 0;
    load_len     = 0;
    dots_seen    = 0;
    glyphs_seen  = 0;
    last_was_dot = 1'b0;
    load_bad     = 1'b0;
    scan_pos     = 0;
    scan_digit   = 0;
  endtask

  // Advances the model by one accepted request and queues any result it owes.
  function automatic void step_panel_model(input ssd_pkg::in_item_t req);
    ssd_pkg::out_item_t r;
    logic [7:0]         c;
    logic [7:0]         seg;
    logic [7:0]         com;
    int                 nd;
    int                 d;
    bit                 ok;
    if (!set_enable) return;
    nd = digits_in_use();
    r = '0;
    if (req.opcode == ssd_pkg::OP_WRITE) begin
      c = fold_case(req.char_code);
      // Characters past the staging bank are dropped, but still counted.
      if (load_len < ssd_pkg::BUFFER_BYTES)
        text_store[(shown_bank ? 0 : ssd_pkg::BUFFER_BYTES) + load_len] = c;
      if (c == ssd_pkg::CHAR_DOT) begin
        if (load_len == 0 || last_was_dot) load_bad = 1'b1;
        if (dots_seen < ssd_pkg::BUFFER_BYTES) dots_seen++;
        last_was_dot = 1'b1;
      end else begin
        if (glyphs_seen < ssd_pkg::BUFFER_BYTES) glyphs_seen++;
        last_was_dot = 1'b0;
      end
      if (load_len < ssd_pkg::BUFFER_BYTES) load_len++;
      if (!req.last_char) return;
      ok = !load_bad && load_len < ssd_pkg::BUFFER_BYTES && dots_seen <= nd &&
           glyphs_seen >= nd;
      if (ok) begin
        // A good string is shown at once and the scan starts over.
        shown_bank = !shown_bank;
        shown_len  = load_len;
        scan_pos   = 0;
        scan_digit = 0;
        strings_shown++;
      end else begin
        strings_refused++;
      end
      load_len     = 0;
      dots_seen    = 0;
      glyphs_seen  = 0;
      last_was_dot = 1'b0;
      load_bad     = 1'b0;
      r.result_kind = ssd_pkg::RES_WRITE;
      r.accepted    = ok;
    end else begin
      d = scan_digit & 7;
      seg = segments_for(shown_at(scan_pos));
      if (scan_pos < ssd_pkg::BUFFER_BYTES) scan_pos++;
      // A dot right after the character lights the decimal point instead.
      if (scan_pos < ssd_pkg::BUFFER_BYTES - 1 && shown_at(scan_pos) == ssd_pkg::CHAR_DOT) begin
        scan_pos++;
        seg = seg | ssd_pkg::SEG_DOT;
      end
      if (!set_seg_high) seg = ~seg;
      com = 8'd1 << d;
      if (!set_com_high) com = ~com;
      scan_digit = d + 1;
      if (scan_digit >= nd) begin
        scan_digit = 0;
        scan_pos   = 0;
      end
      r.result_kind   = ssd_pkg::RES_DRIVE;
      r.segment_lines = seg;
      r.common_lines  = com;
      drives_seen++;
    end
    results_due.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    fault_count++;
    $display("%0t: mismatch in %s: got %02h, expected %02h", $realtime, what, got, want);
  endtask

  // Mostly no gap, often a short one, now and then a long one; none at all
  // while a steady stretch is running.
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A random character other than a dot: often one with a glyph (either
  // case), otherwise any byte at all.
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    if ($urandom_range(0, 9) < 6) begin
      c = 8'($urandom_range(32, 126));
      while (segments_for(fold_case(c)) == 8'h00) c = 8'($urandom_range(32, 126));
    end else begin
      c = 8'($urandom);
      while (c == ssd_pkg::CHAR_DOT) c = 8'($urandom);
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Valid is raised with its payload at a clock edge and held
  // until the edge at which ready is seen with it. It is left high after the
  // handshake so that a back-to-back request only swaps the payload; any
  // caller that pauses lowers it first.
  // --------------------------------------------------------------------------
  task automatic send_request(input ssd_pkg::opcode_t op, input logic [7:0] ch,
                              input bit last);
    ssd_pkg::in_item_t req;
    int                gap;
    req.opcode    = op;
    req.char_code = ch;
    req.last_char = last;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    if (set_enable) items_counted++;
    step_panel_model(req);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++)
      send_request(ssd_pkg::OP_WRITE, text_buf[i], i == text_buf.size() - 1);
  endtask

  // Refresh ticks carry random character and mark bits, which must be ignored.
  task automatic send_refreshes(input int count);
    for (int i = 0; i < count; i++)
      send_request(ssd_pkg::OP_REFRESH, 8'($urandom), 1'($urandom));
  endtask

  task automatic load_literal(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // Appends a string of the given number of non-dot characters, with the
  // given number of dots scattered after distinct ones (never two in a row).
  task automatic build_text(input int glyphs, input int dots);
    int left;
    left = dots;
    for (int i = 0; i < glyphs; i++) begin
      text_buf.push_back(pick_char());
      if (left > 0 && $urandom_range(1, glyphs - i) <= left) begin
        text_buf.push_back(ssd_pkg::CHAR_DOT);
        left--;
      end
    end
  endtask

  task automatic build_good_text(input int nd);
    int dots;
    text_buf.delete();
    dots = $urandom_range(0, nd);
    // Now and then the longest string that still fits the bank.
    if ($urandom_range(0, 19) == 0) build_text(ssd_pkg::BUFFER_BYTES - 1 - dots, dots);
    else build_text($urandom_range(nd, nd + 5), dots);
  endtask

  // Strings that break exactly one rule as built, though a random one may
  // break more.
  task automatic build_bad_text(input int nd);
    int glyphs;
    int dots;
    case ($urandom_range(0, 4))
      0: begin
        build_good_text(nd);
        text_buf.push_front(ssd_pkg::CHAR_DOT);
      end
      1: begin
        build_good_text(nd);
        glyphs = $urandom_range(1, text_buf.size());
        text_buf.insert(glyphs, ssd_pkg::CHAR_DOT);
        text_buf.insert(glyphs, ssd_pkg::CHAR_DOT);
      end
      2: begin
        text_buf.delete();
        dots = nd + 1 + $urandom_range(0, 2);
        build_text(dots + $urandom_range(0, 3), dots);
      end
      3: begin
        text_buf.delete();
        glyphs = $urandom_range(0, nd - 1);
        build_text(glyphs, $urandom_range(0, glyphs));
        if (text_buf.size() == 0) text_buf.push_back(ssd_pkg::CHAR_DOT);
      end
      default: begin
        // Overlong: at or past the bank size.
        text_buf.delete();
        build_text($urandom_range(ssd_pkg::BUFFER_BYTES, ssd_pkg::BUFFER_BYTES + 8), 0);
      end
    endcase
  endtask

  // Stops offering requests and waits until every owed result has come back,
  // then lets a closing-free write that may still be in flight finish.
  task automatic finish_outstanding();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Called only while the driver is idle. Valid is dropped right after
  // the handshake so that the same write is not taken twice.
  task automatic write_register(input ssd_pkg::cfg_reg_t which, input logic [3:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (which)
      ssd_pkg::CFG_ENABLE:        set_enable   = value[0];
      ssd_pkg::CFG_NUM_DIGITS:    set_digits   = value;
      ssd_pkg::CFG_COMMON_HIGH:   set_com_high = value[0];
      ssd_pkg::CFG_SEGMENTS_HIGH: set_seg_high = value[0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side. Ready idles at random in its own process; a requested hold
  // keeps it low for a long, counted stretch.
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_armed) begin
        hold_armed = 1'b0;
        out_ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        out_ready <= 1'b1;
      end else if (rx_gap > 0) begin
        out_ready <= 1'b0;
        rx_gap--;
      end else begin
        out_ready <= 1'b1;
        rx_gap = pick_gap();
      end
    end
  end

  // Every result taken is matched against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        report_mismatch("unrequested result kind", 8'(out_data.result_kind), 8'h00);
      end else begin
        head_result = results_due.pop_front();
        if (out_data.result_kind !== head_result.result_kind)
          report_mismatch("result kind", 8'(out_data.result_kind), 8'(head_result.result_kind));
        if (out_data.accepted !== head_result.accepted)
          report_mismatch("accepted flag", 8'(out_data.accepted), 8'(head_result.accepted));
        if (out_data.segment_lines !== head_result.segment_lines)
          report_mismatch("segment lines", out_data.segment_lines, head_result.segment_lines);
        if (out_data.common_lines !== head_result.common_lines)
          report_mismatch("common lines", out_data.common_lines, head_result.common_lines);
      end
    end
  end

  // Hang detector: counts cycles in which no channel completes a handshake.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Straight after reset nothing is shown, so the first digit drives blank
  // with the default polarities. Then a full house of dots, strings that
  // start with a dot or carry a double dot, and one too short to fill the
  // digits that also holds the NUL code and the top byte.
  task automatic test_directed_strings();
    send_refreshes(1);
    load_literal("8.8.8.8.");
    send_text();
    send_refreshes(4);
    load_literal(".1");
    send_text();
    load_literal("12..34");
    send_text();
    text_buf.delete();
    text_buf.push_back("z");
    text_buf.push_back(8'hFF);
    text_buf.push_back(8'h00);
    send_text();
    // The refused strings must have left the shown one alone.
    send_refreshes(2);
  endtask

  // Walks the digit count through its extremes, including the out-of-range
  // codes that clamp, and every pair of line polarities. Widening the count
  // without a new string makes the scan read past the end of the text.
  task automatic test_digit_counts_and_polarity();
    logic [3:0] counts [6];
    counts = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd4};
    for (int i = 0; i < 6; i++) begin
      finish_outstanding();
      write_register(ssd_pkg::CFG_NUM_DIGITS, counts[i]);
      write_register(ssd_pkg::CFG_COMMON_HIGH, {3'($urandom), 1'(i)});
      write_register(ssd_pkg::CFG_SEGMENTS_HIGH, {3'($urandom), 1'(i >> 1)});
      write_register(ssd_pkg::CFG_ENABLE, {3'($urandom), 1'b1});
      send_refreshes(digits_in_use() + 2);
      build_good_text(digits_in_use());
      send_text();
      send_refreshes(2 * digits_in_use() + 2);
    end
  endtask

  // With the driver switched off requests are swallowed without a trace;
  // afterwards the scan must carry on where it stood.
  task automatic test_disabled_interval();
    finish_outstanding();
    write_register(ssd_pkg::CFG_ENABLE, {3'($urandom), 1'b0});
    for (int i = 0; i < $urandom_range(4, 12); i++)
      send_request(ssd_pkg::opcode_t'($urandom_range(0, 1)), 8'($urandom), 1'($urandom));
    finish_outstanding();
    write_register(ssd_pkg::CFG_ENABLE, {3'($urandom), 1'b1});
    send_refreshes(3);
  endtask

  // The receiver holds off for a long stretch while requests keep coming
  // back to back, so the output fills and the input must stall. Then the
  // sender waits for every result before carrying on.
  task automatic test_output_backpressure();
    steady = 1'b1;
    hold_armed = 1'b1;
    build_good_text(digits_in_use());
    send_text();
    send_refreshes(30);
    steady = 1'b0;
    finish_outstanding();
    build_good_text(digits_in_use());
    send_text();
    finish_outstanding();
    send_refreshes(2 * digits_in_use());
  endtask

  // Mostly well-formed strings with random content, each followed by a few
  // scan ticks; the rest are broken strings and plain noise. Registers are
  // retuned now and then while the driver is idle.
  task automatic test_random_traffic();
    int                 roll;
    ssd_pkg::cfg_reg_t  which;
    logic [3:0]         value;
    while (items_counted < ITEM_TARGET) begin
      steady = ($urandom_range(0, 6) == 0);
      if ($urandom_range(0, 11) == 0) begin
        which = ssd_pkg::cfg_reg_t'($urandom_range(0, 3));
        value = 4'($urandom);
        if (which == ssd_pkg::CFG_ENABLE) value[0] = 1'b1;
        if (which == ssd_pkg::CFG_NUM_DIGITS && $urandom_range(0, 3) != 0)
          value = 4'($urandom_range(1, ssd_pkg::MAX_DIGITS));
        finish_outstanding();
        write_register(which, value);
      end
      if ($urandom_range(0, 59) == 0) test_disabled_interval();
      roll = $urandom_range(0, 99);
      if (roll < 62) begin
        build_good_text(digits_in_use());
        send_text();
      end else if (roll < 87) begin
        build_bad_text(digits_in_use());
        send_text();
      end else begin
        for (int i = 0; i < $urandom_range(1, 8); i++)
          send_request(ssd_pkg::opcode_t'($urandom_range(0, 1)), 8'($urandom),
                       $urandom_range(0, 5) == 0);
      end
      send_refreshes($urandom_range(1, 2 * digits_in_use() + 3));
    end
    steady = 1'b0;
  endtask

  initial begin
    reset_panel_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_strings();
    test_digit_counts_and_polarity();
    test_disabled_interval();
    test_output_backpressure();
    test_random_traffic();
    finish_outstanding();

    $display("Ran %0d enabled requests over %0d register writes with random idling.",
             items_counted, reg_writes);
    $display("Strings shown %0d, strings refused %0d, scan outputs %0d, mismatches %0d.",
             strings_shown, strings_refused, drives_seen, fault_count);
    if (fault_count == 0 && results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/ssd_pkg.sv
design/seven_segment_scan_driver.sv
tb/seven_segment_scan_driver_test.sv
